// File: rtl/scaled_decimal_compare_assert.svh
// Assertion macros for the scaled decimal compare block.
// Used by scaled_decimal_compare.sv; expects clk and arst_n in scope.
`ifndef SCALED_DECIMAL_COMPARE_ASSERT_SVH
`define SCALED_DECIMAL_COMPARE_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define SDC_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scaled_decimal_compare: implication check failed");

// Next-cycle implication, checked out of reset
`define SDC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scaled_decimal_compare: next-cycle check failed");

`endif

// File: rtl/sdc_pkg.sv
// Shared constants, types and state codes for the scaled decimal compare block.
// No dependencies.
`default_nettype none

package sdc_pkg;

	// Operand format
	localparam int MAX_SCALE    = 28;
	localparam int MANT_BITS    = 96;
	localparam int MANT_FIELD_W = 96;
	localparam int SCALE_W      = 5;

	// Working magnitude: seven 32-bit limbs, wide enough for 96 bits times 10^28
	localparam int LIMB_W  = 32;
	localparam int LIMBS   = 7;
	localparam int WIDE_W  = LIMBS * LIMB_W;
	localparam int CARRY_W = 4;

	// Stream widths
	localparam int IN_DATA_W  = 208;
	localparam int OUT_DATA_W = 8;

	// Mantissa bits at or above MANT_BITS are ignored
	localparam logic [MANT_FIELD_W-1:0] MANT_MASK =
		{MANT_FIELD_W{1'b1}} >> (MANT_FIELD_W - MANT_BITS);

	// Per-cell control
	typedef struct packed {
		logic load;
		logic step;
		logic sel_a;
	} cell_ctl_t;

	// Magnitude compare result, a against b
	typedef struct packed {
		logic gt;
		logic lt;
	} mag_cmp_t;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCALE = 3'b010,
		ST_CMP   = 3'b100
	} state_t;

endpackage

`default_nettype wire

// File: rtl/sdc_cell.sv
// One limb cell of the magnitude chain: holds a 32-bit limb of each operand,
// multiplies one of them by ten with a ripple carry, and compares. Uses sdc_pkg.
`default_nettype none

module sdc_cell
	import sdc_pkg::*;
(
	input  wire logic              clk,
	input  wire cell_ctl_t         ctl,
	input  wire logic [LIMB_W-1:0] a_load,
	input  wire logic [LIMB_W-1:0] b_load,
	input  wire logic [CARRY_W-1:0] cin,
	output logic [CARRY_W-1:0]     cout,
	input  wire mag_cmp_t          cmp_hi,
	output mag_cmp_t               cmp_out
);

	logic [LIMB_W-1:0]         a_q;
	logic [LIMB_W-1:0]         b_q;
	logic [LIMB_W-1:0]         mul_src;
	logic [LIMB_W+CARRY_W-1:0] prod;

	// limb * 10 + carry in, as x*8 + x*2 + cin
	always_comb begin
		mul_src = ctl.sel_a ? a_q : b_q;
		prod    = {{(CARRY_W-3){1'b0}}, mul_src, 3'b000}
			+ {{(CARRY_W-1){1'b0}}, mul_src, 1'b0}
			+ {{LIMB_W{1'b0}}, cin};
		cout    = prod[LIMB_W+CARRY_W-1:LIMB_W];
	end

	// Limb registers
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			a_q <= a_load;
			b_q <= b_load;
		end else if (ctl.step) begin
			if (ctl.sel_a) begin
				a_q <= prod[LIMB_W-1:0];
			end else begin
				b_q <= prod[LIMB_W-1:0];
			end
		end
	end

	// Higher limbs decide first; equal so far falls to this limb
	always_comb begin
		if (cmp_hi.gt || cmp_hi.lt) begin
			cmp_out = cmp_hi;
		end else begin
			cmp_out.gt = (a_q > b_q);
			cmp_out.lt = (a_q < b_q);
		end
	end

endmodule

`default_nettype wire

// File: rtl/scaled_decimal_compare.sv
// Top level of the scaled decimal compare block: control, limb cell chain,
// output register. Uses sdc_pkg, sdc_cell and scaled_decimal_compare_assert.svh.
//
// Usage:
//   s_axis carries one pair of operands a, b per transfer (mantissa, scale,
//   sign each). m_axis returns one transfer per pair: is_equal and is_less.
//   Scales above 28 saturate to 28; -0 and +0 compare equal.
//   The mantissa with the smaller scale is multiplied by ten once per cycle
//   in a chain of seven 32-bit limb cells, the carry rippling along the chain.
//   An item therefore passes from the input transfer to m_axis_tvalid through
//   d decimal steps in the cell chain, d being the difference of the two
//   saturated scales (0 to 28), and then through the limb compare.
//   A new input transfer is taken in the cycle after the result is registered,
//   so no new pair is taken while the last one is still being worked on.
//   A result waits in the output register while m_axis_tready is low; the
//   block still accepts the next pair and works on it, and holds in the
//   compare step until the output register frees up.
//   Reset (arst_n low) empties the output register and returns to idle.
`default_nettype none
`include "scaled_decimal_compare_assert.svh"

module scaled_decimal_compare
	import sdc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// a_mant_lo[63:0], a_mant_hi[95:64], a_scale[100:96], a_negative[101],
	// b_mant_lo[165:102], b_mant_hi[197:166], b_scale[202:198], b_negative[203], zero
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// is_equal[0], is_less[1], zero
	output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

	// Input field unpacking
	logic [MANT_FIELD_W-1:0] a_mant;
	logic [MANT_FIELD_W-1:0] b_mant;
	logic [SCALE_W-1:0]      a_scale;
	logic [SCALE_W-1:0]      b_scale;
	logic                    a_negative;
	logic                    b_negative;

	assign a_mant     = {s_axis_tdata[95:64], s_axis_tdata[63:0]} & MANT_MASK;
	assign a_scale    = s_axis_tdata[100:96];
	assign a_negative = s_axis_tdata[101];
	assign b_mant     = {s_axis_tdata[197:166], s_axis_tdata[165:102]} & MANT_MASK;
	assign b_scale    = s_axis_tdata[202:198];
	assign b_negative = s_axis_tdata[203];

	// Scale saturation and difference
	logic [SCALE_W-1:0] a_sat;
	logic [SCALE_W-1:0] b_sat;
	logic [SCALE_W-1:0] diff;
	logic               scale_a;

	always_comb begin
		a_sat   = (a_scale > SCALE_W'(MAX_SCALE)) ? SCALE_W'(MAX_SCALE) : a_scale;
		b_sat   = (b_scale > SCALE_W'(MAX_SCALE)) ? SCALE_W'(MAX_SCALE) : b_scale;
		scale_a = (b_sat > a_sat);
		diff    = scale_a ? (b_sat - a_sat) : (a_sat - b_sat);
	end

	// Control and per-item registers
	state_t             state_q;
	state_t             state_d;
	logic [SCALE_W-1:0] cnt_q;
	logic               sel_a_q;
	logic               a_neg_q;
	logic               b_neg_q;
	logic               both_zero_q;
	logic               m_valid_q;
	logic [1:0]         m_data_q;
	logic               s_acc;
	logic               out_free;
	logic               out_load;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign out_load      = (state_q == ST_CMP) && out_free;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					state_d = (diff == '0) ? ST_CMP : ST_SCALE;
				end
			end
			ST_SCALE: begin
				if (cnt_q == SCALE_W'(1)) begin
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (s_acc) begin
				cnt_q <= diff;
			end else if (state_q == ST_SCALE) begin
				cnt_q <= cnt_q - SCALE_W'(1);
			end
		end
	end

	// Item flags captured on the input transfer
	always_ff @(posedge clk) begin
		if (s_acc) begin
			sel_a_q     <= scale_a;
			a_neg_q     <= a_negative;
			b_neg_q     <= b_negative;
			both_zero_q <= (a_mant == '0) && (b_mant == '0);
		end
	end

	// Limb cell chain
	logic [WIDE_W-1:0]  a_wide;
	logic [WIDE_W-1:0]  b_wide;
	cell_ctl_t          ctl;
	logic [CARRY_W-1:0] carry [LIMBS];
	mag_cmp_t           cmp_ch [LIMBS+1];

	assign a_wide    = {{(WIDE_W-MANT_FIELD_W){1'b0}}, a_mant};
	assign b_wide    = {{(WIDE_W-MANT_FIELD_W){1'b0}}, b_mant};
	assign ctl.load  = s_acc;
	assign ctl.step  = (state_q == ST_SCALE);
	assign ctl.sel_a = sel_a_q;
	assign carry[0]  = '0;
	assign cmp_ch[LIMBS] = '0;

	for (genvar i = 0; i < LIMBS; i++) begin : g_cell
		if (i < LIMBS - 1) begin : g_mid
			sdc_cell u_cell (
				.clk     (clk),
				.ctl     (ctl),
				.a_load  (a_wide[i*LIMB_W +: LIMB_W]),
				.b_load  (b_wide[i*LIMB_W +: LIMB_W]),
				.cin     (carry[i]),
				.cout    (carry[i+1]),
				.cmp_hi  (cmp_ch[i+1]),
				.cmp_out (cmp_ch[i])
			);
		end else begin : g_top
			// Product never reaches the top limb's carry out
			sdc_cell u_cell (
				.clk     (clk),
				.ctl     (ctl),
				.a_load  (a_wide[i*LIMB_W +: LIMB_W]),
				.b_load  (b_wide[i*LIMB_W +: LIMB_W]),
				.cin     (carry[i]),
				.cout    (),
				.cmp_hi  (cmp_ch[i+1]),
				.cmp_out (cmp_ch[i])
			);
		end
	end

	// Sign and zero resolution
	logic res_eq;
	logic res_lt;

	always_comb begin
		res_eq = both_zero_q
			|| (!cmp_ch[0].gt && !cmp_ch[0].lt && (a_neg_q == b_neg_q));
		if (res_eq) begin
			res_lt = 1'b0;
		end else if (a_neg_q != b_neg_q) begin
			res_lt = a_neg_q;
		end else if (a_neg_q) begin
			res_lt = cmp_ch[0].gt;
		end else begin
			res_lt = cmp_ch[0].lt;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= {res_lt, res_eq};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W-2){1'b0}}, m_data_q};

	// Checks
	`SDC_ASSERT_NEXT(a_scale_entry, s_acc && (diff != '0), state_q == ST_SCALE)
	`SDC_ASSERT_IMPL(a_scale_cnt, state_q == ST_SCALE, cnt_q != '0)
	`SDC_ASSERT_NEXT(a_result_load, out_load, m_axis_tvalid && (state_q == ST_IDLE))
	`SDC_ASSERT_IMPL(a_eq_lt_excl, m_axis_tvalid, !(m_axis_tdata[0] && m_axis_tdata[1]))

endmodule

`default_nettype wire
